@@ design/lprl_pkg.sv @@
// lprl_pkg: shared widths, function codes, control structs and the
// leading-ones count for the longest prefix route lookup
// no dependencies
package lprl_pkg;

    localparam int ROUTE_ENTRIES_DEF = 16;
    localparam int ADDR_W            = 32;
    localparam int INDEX_W           = 4;
    localparam int LEN_W             = 6;
    localparam int INDEX_SLOTS       = 1 << INDEX_W;

    // function codes carried by the func field
    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } lprl_state_t;

    // controller to datapath commands
    typedef struct packed {
        logic start;
        logic scan;
        logic rsp_load;
    } lprl_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic scan_last;
        logic out_free;
    } lprl_status_t;

    // length of the leading run of ones, 0..32
    function automatic logic [LEN_W-1:0] lead_ones(input logic [ADDR_W-1:0] m);
        logic [LEN_W-1:0] n;
        n = LEN_W'(ADDR_W);
        // highest zero bit decides, later iterations override earlier ones
        for (int i = 0; i < ADDR_W; i++)
        begin
            if (!m[i])
            begin
                n = LEN_W'(ADDR_W - 1 - i);
            end
        end
        return n;
    endfunction

endpackage

@@ design/lprl_req_if.sv @@
// lprl_req_if: request channel, valid/ready plus write and lookup payload
// depends on lprl_pkg
interface lprl_req_if
    import lprl_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               func;
    logic [INDEX_W-1:0] entry_index;
    logic               entry_valid;
    logic [ADDR_W-1:0]  entry_prefix;
    logic [ADDR_W-1:0]  entry_mask;
    logic [ADDR_W-1:0]  lookup_addr;

    modport source (
        output valid, func, entry_index, entry_valid, entry_prefix, entry_mask,
               lookup_addr,
        input  ready
    );

    modport sink (
        input  valid, func, entry_index, entry_valid, entry_prefix, entry_mask,
               lookup_addr,
        output ready
    );
endinterface

@@ design/lprl_rsp_if.sv @@
// lprl_rsp_if: response channel, valid/ready plus lookup result payload
// depends on lprl_pkg
interface lprl_rsp_if
    import lprl_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               hit;
    logic [INDEX_W-1:0] best_index;
    logic [LEN_W-1:0]   best_length;

    modport source (
        output valid, hit, best_index, best_length,
        input  ready
    );

    modport sink (
        input  valid, hit, best_index, best_length,
        output ready
    );
endinterface

@@ design/lprl_ctrl.sv @@
// lprl_ctrl: transaction sequencer for writes and table scans
// depends on lprl_pkg
module lprl_ctrl
    import lprl_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         req_valid,
    input  logic         req_func,
    output logic         req_ready,
    input  lprl_status_t status,
    output lprl_cmd_t    cmd
);

    lprl_state_t state_reg;
    lprl_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = (req_func == FUNC_LOOKUP) ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN:
            begin
                if (status.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        req_ready    = 1'b0;
        cmd.start    = 1'b0;
        cmd.scan     = 1'b0;
        cmd.rsp_load = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                cmd.start = req_valid;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            ST_DRAIN:
            begin
            end
            ST_DONE:
            begin
                cmd.rsp_load = status.out_free;
            end
            default:
            begin
            end
        endcase
    end

endmodule

@@ design/lprl_dp.sv @@
// lprl_dp: route table storage, scan counter, match compare, best tracking
// and the response register; depends on lprl_pkg and the channel interfaces
module lprl_dp
    import lprl_pkg::*;
#(
    parameter int ROUTE_ENTRIES = ROUTE_ENTRIES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    lprl_req_if.sink      req,
    lprl_rsp_if.source    rsp,
    input  lprl_cmd_t     cmd,
    output lprl_status_t  status
);

    // only slots reachable by the index field can ever become valid
    localparam int SLOTS = (ROUTE_ENTRIES < INDEX_SLOTS) ? ROUTE_ENTRIES : INDEX_SLOTS;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [ADDR_W-1:0] prefix_mem [SLOTS];
    logic [ADDR_W-1:0] mask_mem   [SLOTS];
    logic [SLOTS-1:0]  valid_reg;

    logic [IDX_W-1:0]  cnt_reg;
    logic [ADDR_W-1:0] addr_reg;

    logic              rd_pend_reg;
    logic              rd_valid_reg;
    logic [IDX_W-1:0]  rd_idx_reg;
    logic [ADDR_W-1:0] rd_prefix_reg;
    logic [ADDR_W-1:0] rd_mask_reg;

    logic               hit_reg;
    logic [INDEX_W-1:0] idx_reg;
    logic [LEN_W-1:0]   len_reg;

    logic               out_valid_reg;
    logic               out_hit_reg;
    logic [INDEX_W-1:0] out_idx_reg;
    logic [LEN_W-1:0]   out_len_reg;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic               match;
    logic [LEN_W-1:0]   cand_len;
    logic               take;

    // table write decode, out of range slots are dropped
    assign wr_en   = cmd.start && (req.func == FUNC_WRITE)
                     && (int'(req.entry_index) < ROUTE_ENTRIES);
    assign wr_addr = IDX_W'(req.entry_index);

    // prefix and mask storage, no reset
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            prefix_mem[wr_addr] <= req.entry_prefix;
            mask_mem[wr_addr]   <= req.entry_mask;
        end
        if (cmd.scan)
        begin
            rd_prefix_reg <= prefix_mem[cnt_reg];
            rd_mask_reg   <= mask_mem[cnt_reg];
        end
    end

    // valid bits, scan counter and read pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            cnt_reg      <= '0;
            rd_pend_reg  <= 1'b0;
            rd_valid_reg <= 1'b0;
            rd_idx_reg   <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= req.entry_valid;
            end
            if (cmd.start)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.scan)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            rd_pend_reg <= cmd.scan;
            if (cmd.scan)
            begin
                rd_valid_reg <= valid_reg[cnt_reg];
                rd_idx_reg   <= cnt_reg;
            end
        end
    end

    // lookup address capture
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            addr_reg <= req.lookup_addr;
        end
    end

    // compare the fetched entry against the address
    assign match    = rd_valid_reg && (((addr_reg ^ rd_prefix_reg) & rd_mask_reg) == '0);
    assign cand_len = lead_ones(rd_mask_reg);
    assign take     = rd_pend_reg && match && (!hit_reg || (cand_len > len_reg));

    // running best, strict compare keeps the lower index on ties
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
            idx_reg <= '0;
            len_reg <= '0;
        end
        else if (cmd.start)
        begin
            hit_reg <= 1'b0;
            idx_reg <= '0;
            len_reg <= '0;
        end
        else if (take)
        begin
            hit_reg <= 1'b1;
            idx_reg <= INDEX_W'(rd_idx_reg);
            len_reg <= cand_len;
        end
    end

    // response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.rsp_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rsp_load)
        begin
            out_hit_reg <= hit_reg;
            out_idx_reg <= idx_reg;
            out_len_reg <= len_reg;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.hit         = out_hit_reg;
    assign rsp.best_index  = out_idx_reg;
    assign rsp.best_length = out_len_reg;

    assign status.scan_last = (cnt_reg == IDX_W'(SLOTS - 1));
    assign status.out_free  = !out_valid_reg || rsp.ready;

endmodule

@@ design/longest_prefix_route_lookup.sv @@
// longest prefix route lookup, one transaction at a time
// write: response loaded in the done state once the response register is free
// lookup: N = min(ROUTE_ENTRIES, 16) entries scanned
//   one entry a cycle through the table read port, then the drain and done states
// reset: asynchronous active low, clears all route valid bits and control;
//   prefix and mask storage is not cleared
module longest_prefix_route_lookup
    import lprl_pkg::*;
#(
    parameter int ROUTE_ENTRIES = ROUTE_ENTRIES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    lprl_req_if.sink   req,
    lprl_rsp_if.source rsp
);

    lprl_cmd_t    cmd;
    lprl_status_t status;
    logic         ctrl_ready;

    // sequencer
    lprl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_func  (req.func),
        .req_ready (ctrl_ready),
        .status    (status),
        .cmd       (cmd)
    );

    assign req.ready = ctrl_ready;

    // table and compare datapath
    lprl_dp #(
        .ROUTE_ENTRIES (ROUTE_ENTRIES)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .rsp    (rsp),
        .cmd    (cmd),
        .status (status)
    );

    // a miss reports zero index and length
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.hit) |-> (rsp.best_index == '0 && rsp.best_length == '0))
        else $error("miss response with nonzero index or length");

    // prefix length never exceeds the address width
    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.best_length <= LEN_W'(ADDR_W)))
        else $error("prefix length out of range");

    // one transaction in flight: no accept right after an accept
    a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request accepted while busy");

endmodule

@@ sim/longest_prefix_route_lookup_tb.sv @@
`timescale 1ns / 100ps
// longest_prefix_route_lookup_tb: self-checking bench for the longest prefix route lookup
// depends on lprl_pkg, lprl_req_if, lprl_rsp_if and longest_prefix_route_lookup
module longest_prefix_route_lookup_tb;
    import lprl_pkg::*;

    localparam int SLOTS         = ROUTE_ENTRIES_DEF;
    localparam int SETTLE_CYCLES = 40;       // idle wait once every outstanding result has been drained
    localparam int CYCLE_LIMIT   = 400000;
    localparam int LONG_HOLD     = 400;

    typedef struct {
        bit               func;
        bit [INDEX_W-1:0] index;
        bit               valid;
        bit [ADDR_W-1:0]  prefix;
        bit [ADDR_W-1:0]  mask;
        bit [ADDR_W-1:0]  addr;
    } route_req_t;

    typedef struct {
        bit               hit;
        bit [INDEX_W-1:0] index;
        bit [LEN_W-1:0]   length;
    } route_rsp_t;

    logic clk = 1'b0;
    logic rst_n;

    lprl_req_if req_if ();
    lprl_rsp_if rsp_if ();

    longest_prefix_route_lookup dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // bench copy of the route table
    bit              table_valid [SLOTS];
    bit [ADDR_W-1:0] table_prefix[SLOTS];
    bit [ADDR_W-1:0] table_mask  [SLOTS];

    route_rsp_t expected_routes[$];

    int    send_idle_pct = 0;
    int    recv_idle_pct = 0;
    int    recv_hold     = 0;
    int    mismatches    = 0;
    int    writes_sent   = 0;
    int    lookups_sent  = 0;
    int    hits_seen     = 0;
    longint cycles       = 0;

    always #1 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("longest_prefix_route_lookup: mismatch");
            $finish;
        end
    end

    // length of the leading run of ones in a mask
    function automatic int mask_length(input bit [ADDR_W-1:0] m);
        int n;
        n = 0;
        while (n < ADDR_W && m[ADDR_W-1-n])
        begin
            n++;
        end
        return n;
    endfunction

    // contiguous mask with len leading ones
    function automatic bit [ADDR_W-1:0] prefix_mask(input int len);
        return ~({ADDR_W{1'b1}} >> len);
    endfunction

    // update the table on a write, scan it on a lookup
    function automatic route_rsp_t predict_route(input route_req_t r);
        route_rsp_t res;
        int         len;
        res.hit    = 1'b0;
        res.index  = '0;
        res.length = '0;
        if (r.func == FUNC_WRITE)
        begin
            table_valid[r.index]  = r.valid;
            table_prefix[r.index] = r.prefix;
            table_mask[r.index]   = r.mask;
        end
        else
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                if (table_valid[i] && ((r.addr & table_mask[i]) == (table_prefix[i] & table_mask[i])))
                begin
                    len = mask_length(table_mask[i]);
                    if (!res.hit || len > int'(res.length))
                    begin
                        res.hit    = 1'b1;
                        res.index  = INDEX_W'(i);
                        res.length = LEN_W'(len);
                    end
                end
            end
        end
        return res;
    endfunction

    // write transaction, lookup address filled with noise
    function automatic route_req_t write_req(input int idx, input bit vld,
                                             input bit [ADDR_W-1:0] prefix,
                                             input bit [ADDR_W-1:0] mask);
        route_req_t r;
        r.func   = FUNC_WRITE;
        r.index  = INDEX_W'(idx);
        r.valid  = vld;
        r.prefix = prefix;
        r.mask   = mask;
        r.addr   = $urandom;
        return r;
    endfunction

    // lookup transaction, entry fields filled with noise
    function automatic route_req_t lookup_req(input bit [ADDR_W-1:0] addr);
        route_req_t r;
        r.func   = FUNC_LOOKUP;
        r.index  = INDEX_W'($urandom_range(SLOTS - 1));
        r.valid  = 1'($urandom_range(1));
        r.prefix = $urandom;
        r.mask   = $urandom;
        r.addr   = addr;
        return r;
    endfunction

    // offer one transaction after a random gap and wait until it is taken
    task automatic send_route(input route_req_t r);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(negedge clk);
        end
        req_if.valid        <= 1'b1;
        req_if.func         <= r.func;
        req_if.entry_index  <= r.index;
        req_if.entry_valid  <= r.valid;
        req_if.entry_prefix <= r.prefix;
        req_if.entry_mask   <= r.mask;
        req_if.lookup_addr  <= r.addr;
        do
            @(posedge clk);
        while (!req_if.ready);
        expected_routes.push_back(predict_route(r));
        if (r.func == FUNC_WRITE)
            writes_sent++;
        else
            lookups_sent++;
    endtask

    // drop valid, wait for every outstanding result, then let the block settle
    task automatic wait_settled();
        @(negedge clk);
        req_if.valid <= 1'b0;
        while (expected_routes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // random write, mostly contiguous masks, prefixes often nested in existing ones
    function automatic route_req_t random_write();
        bit [ADDR_W-1:0]  mask;
        bit [ADDR_W-1:0]  prefix;
        bit [ADDR_W-1:0]  keep;
        bit [INDEX_W-1:0] src;
        int               pick;
        pick = $urandom_range(99);
        if (pick < 80)
            mask = prefix_mask($urandom_range(ADDR_W));
        else if (pick < 90)
            mask = $urandom;
        else
            mask = $urandom_range(1) ? '1 : '0;
        if ($urandom_range(1))
        begin
            keep   = prefix_mask($urandom_range(ADDR_W));
            src    = INDEX_W'($urandom_range(SLOTS - 1));
            prefix = (table_prefix[src] & keep) | ($urandom & ~keep);
        end
        else
        begin
            prefix = $urandom;
        end
        return write_req($urandom_range(SLOTS - 1), $urandom_range(99) < 85, prefix, mask);
    endfunction

    // random lookup, mostly aimed at a stored route
    function automatic bit [ADDR_W-1:0] random_addr();
        bit [INDEX_W-1:0] s;
        int               pick;
        bit [ADDR_W-1:0]  a;
        s    = INDEX_W'($urandom_range(SLOTS - 1));
        a    = (table_prefix[s] & table_mask[s]) | ($urandom & ~table_mask[s]);
        pick = $urandom_range(99);
        if (pick < 70)
            return a;
        else if (pick < 80)
            return $urandom;
        else if (pick < 90)
            return $urandom_range(1) ? '1 : '0;
        // near miss: one bit flipped
        return a ^ (32'h1 << $urandom_range(ADDR_W - 1));
    endfunction

    // response side: random stalls plus the long hold-off
    always @(negedge clk)
    begin
        if (recv_hold > 0)
        begin
            recv_hold--;
            rsp_if.ready <= 1'b0;
        end
        else
        begin
            rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // compare each result with the oldest expectation
    always @(posedge clk)
    begin
        route_rsp_t exp_rsp;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (expected_routes.size() == 0)
            begin
                $display("%0t: unexpected result hit=%0b index=%0d length=%0d", $time,
                         rsp_if.hit, rsp_if.best_index, rsp_if.best_length);
                mismatches++;
            end
            else
            begin
                exp_rsp = expected_routes.pop_front();
                if (rsp_if.hit !== exp_rsp.hit)
                begin
                    $display("%0t: hit expected %0b actual %0b", $time, exp_rsp.hit, rsp_if.hit);
                    mismatches++;
                end
                if (rsp_if.best_index !== exp_rsp.index)
                begin
                    $display("%0t: best_index expected %0d actual %0d", $time,
                             exp_rsp.index, rsp_if.best_index);
                    mismatches++;
                end
                if (rsp_if.best_length !== exp_rsp.length)
                begin
                    $display("%0t: best_length expected %0d actual %0d", $time,
                             exp_rsp.length, rsp_if.best_length);
                    mismatches++;
                end
                if (exp_rsp.hit)
                    hits_seen++;
            end
        end
    end

    // lookups against an empty table and an invalid entry
    task automatic test_empty_table();
        send_route(lookup_req('0));
        send_route(lookup_req('1));
        send_route(write_req(4, 1'b0, '1, '1));
        send_route(lookup_req('1));
    endtask

    // default route, host route, ties, non-contiguous mask, invalidation
    task automatic test_directed_routes();
        send_route(write_req(15, 1'b1, 32'h0000_0000, 32'h0000_0000));
        send_route(lookup_req(32'hC0A8_0101));
        send_route(write_req(3, 1'b1, 32'h0A00_0000, prefix_mask(8)));
        send_route(write_req(7, 1'b1, 32'h0A01_0200, prefix_mask(24)));
        send_route(write_req(9, 1'b1, 32'h0A01_0200, prefix_mask(24)));
        send_route(write_req(0, 1'b1, 32'h0A01_0203, prefix_mask(32)));
        send_route(write_req(5, 1'b1, 32'h0A00_0003, 32'hFF00_00FF));
        send_route(write_req(12, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_route(lookup_req(32'h0A01_0203));
        send_route(lookup_req(32'h0A01_0204));
        send_route(lookup_req(32'h0A7F_0003));
        send_route(lookup_req(32'h0B00_0000));
        send_route(lookup_req(32'hFFFF_FFFF));
        // drop the first of two equal routes, the second takes over
        send_route(write_req(7, 1'b0, 32'h0A01_0200, prefix_mask(24)));
        send_route(lookup_req(32'h0A01_0204));
        // drop the default route
        send_route(write_req(15, 1'b0, 32'h0000_0000, 32'h0000_0000));
        send_route(lookup_req(32'hC0A8_0101));
    endtask

    // mixed writes and lookups under a given idle mix
    task automatic test_random_traffic(input int count, input int s_pct, input int r_pct);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(99) < 30)
                send_route(random_write());
            else
                send_route(lookup_req(random_addr()));
        end
    endtask

    // long receive stall while the sender keeps offering
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        recv_hold     = LONG_HOLD;
        for (int n = 0; n < 24; n++)
        begin
            send_route(lookup_req(random_addr()));
        end
        wait_settled();
    endtask

    initial
    begin
        rst_n               = 1'b0;
        req_if.valid        = 1'b0;
        req_if.func         = FUNC_WRITE;
        req_if.entry_index  = '0;
        req_if.entry_valid  = 1'b0;
        req_if.entry_prefix = '0;
        req_if.entry_mask   = '0;
        req_if.lookup_addr  = '0;
        rsp_if.ready        = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_table();
        test_directed_routes();
        wait_settled();
        test_random_traffic(500, 31, 48);
        test_backpressure();
        test_random_traffic(500, 48, 31);
        // sender pause until the block has drained
        wait_settled();
        test_random_traffic(500, 0, 0);
        wait_settled();

        $display("run covered %0d writes and %0d lookups, %0d lookups hit", writes_sent,
                 lookups_sent, hits_seen);
        $display("idle mixes 31/48, 48/31 and none, plus one long response stall");
        if (mismatches == 0 && expected_routes.size() == 0)
        begin
            $display("longest_prefix_route_lookup: match");
        end
        else
        begin
            $display("longest_prefix_route_lookup: mismatch");
        end
        $finish;
    end

endmodule
